[sv/srdz_pkg.sv]
// constants, register codes and carried side-band type for the stick radial deadzone block
// no dependencies; compile first
package srdz_pkg;

  localparam int LANES      = 2;
  localparam int RAW_W      = 8;
  localparam int AX_W       = 8;
  localparam int DZ_W       = 16;
  localparam int OUT_W      = 16;
  localparam int M2_W       = 16;
  localparam int R_W        = 24;
  localparam int SQ_STEPS   = 24;
  localparam int SQ_REM_W   = 26;
  localparam int DQ_SHIFT   = 7;
  localparam int MULT_W     = 25;
  localparam int MULT_STEPS = 25;
  localparam int DIV_REM_W  = 25;
  localparam int RND_SHIFT  = 24;
  localparam int CFG_IDX_W  = 1;

  localparam logic [R_W-1:0]       ONE_Q23   = 24'h80_0000;
  localparam logic [DZ_W-1:0]      DZ_RESET  = 16'd10486;
  localparam logic [OUT_W:0]       POS_LIMIT = 17'd32767;
  localparam logic [OUT_W:0]       NEG_LIMIT = 17'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 1'b1;

  // per-stick info that rides along the pipe
  typedef struct packed {
    logic [1:0][AX_W-1:0] ax;
    logic [1:0]           neg;
    logic                 zero;
  } side_t;

endpackage

[sv/srdz_samp_if.sv]
// raw sample channel and result channel of the stick radial deadzone block
// depends on srdz_pkg
interface srdz_samp_if;
  logic                         valid;
  logic                         ready;
  logic [srdz_pkg::RAW_W-1:0]   left_horiz_raw;
  logic [srdz_pkg::RAW_W-1:0]   left_vert_raw;
  logic [srdz_pkg::RAW_W-1:0]   right_horiz_raw;
  logic [srdz_pkg::RAW_W-1:0]   right_vert_raw;

  modport source (output valid, left_horiz_raw, left_vert_raw, right_horiz_raw,
                  right_vert_raw, input ready);
  modport sink   (input valid, left_horiz_raw, left_vert_raw, right_horiz_raw,
                  right_vert_raw, output ready);
endinterface

interface srdz_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [srdz_pkg::OUT_W-1:0] left_horiz_out;
  logic signed [srdz_pkg::OUT_W-1:0] left_vert_out;
  logic signed [srdz_pkg::OUT_W-1:0] right_horiz_out;
  logic signed [srdz_pkg::OUT_W-1:0] right_vert_out;

  modport source (output valid, left_horiz_out, left_vert_out, right_horiz_out,
                  right_vert_out, input ready);
  modport sink   (input valid, left_horiz_out, left_vert_out, right_horiz_out,
                  right_vert_out, output ready);
endinterface

[sv/stick_radial_deadzone_top.sv]
// stick radial deadzone: two sticks, magnitude by pipelined square root, scale by
// pipelined dividers, one multiply and round/saturate; depends on srdz_pkg and srdz_samp_if.sv
//
//   channel   dir  handshake      payload
//   samp      in   valid/ready    four raw bytes, 128 is centre
//   res       out  valid/ready    four signed Q1.15 axes
//   cfg       in   cfg_we         cfg_index selects deadzone, cfg_data 16 bits
//
// one item per cycle while res is not stalled; the pipe holds the 24 square root stages
// and the restoring divider stages
// rst clears the valid bits and loads both deadzones with 10486
// a stall on res freezes the whole pipe; samp.ready follows res.ready when the last stage is full
module stick_radial_deadzone_top #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srdz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srdz_pkg::DZ_W-1:0]      cfg_data,
  srdz_samp_if.sink                      samp,
  srdz_res_if.source                     res
);
  import srdz_pkg::*;

  localparam int UQ_W      = OUT_FRAC_BITS + 1;
  localparam int DIV_STEPS = (MULT_STEPS > UQ_W) ? MULT_STEPS : UQ_W;
  localparam int PROD_W    = UQ_W + MULT_W;
  localparam int MAG_W     = PROD_W - RND_SHIFT;
  localparam int MX_W      = (MAG_W > OUT_W + 1) ? MAG_W : OUT_W + 1;
  localparam int NST       = 4 + SQ_STEPS + DIV_STEPS;
  localparam int PAIRS     = M2_W / 2;

  logic [DZ_W-1:0] dz [LANES];
  logic [NST-1:0]  vld;
  logic            en;

  logic [RAW_W-1:0] raw [LANES][2];

  logic [M2_W-1:0]     m2s     [LANES][SQ_STEPS+1];
  side_t               side_sq [LANES][SQ_STEPS+1];
  logic [SQ_REM_W-1:0] sq_rem  [LANES][1:SQ_STEPS];
  logic [R_W-1:0]      sq_root [LANES][1:SQ_STEPS];

  logic [DIV_REM_W-1:0] dm_rem  [LANES][DIV_STEPS+1];
  logic [R_W-1:0]       dm_div  [LANES][DIV_STEPS+1];
  logic [MULT_W-1:0]    dm_q    [LANES][DIV_STEPS+1];
  logic [DIV_REM_W-1:0] du_rem  [LANES][2][DIV_STEPS+1];
  logic [UQ_W-1:0]      du_q    [LANES][2][DIV_STEPS+1];
  logic [R_W-1:0]       dv_r    [LANES][DIV_STEPS+1];
  side_t                side_dv [LANES][DIV_STEPS+1];

  logic [PROD_W-1:0] prod    [LANES][2];
  side_t             side_ml [LANES];
  logic [OUT_W-1:0]  ores    [LANES][2];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dz[0] <= DZ_RESET;
      dz[1] <= DZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_DZ:  dz[0] <= cfg_data;
        REG_RIGHT_DZ: dz[1] <= cfg_data;
      endcase
    end
  end

  assign en         = !vld[NST-1] || res.ready;
  assign samp.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], samp.valid};
    end
  end

  assign raw[0][0] = samp.left_horiz_raw;
  assign raw[0][1] = samp.left_vert_raw;
  assign raw[1][0] = samp.right_horiz_raw;
  assign raw[1][1] = samp.right_vert_raw;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // centre and square
    logic [AX_W-1:0] ax0 [2];
    logic [M2_W-1:0] m2w;
    for (genvar a = 0; a < 2; a++) begin : g_ax
      assign ax0[a] = raw[l][a][RAW_W-1] ? {1'b0, raw[l][a][RAW_W-2:0]}
                                         : AX_W'(9'd128 - {1'b0, raw[l][a]});
    end
    assign m2w = M2_W'(ax0[0] * ax0[0]) + M2_W'(ax0[1] * ax0[1]);

    always_ff @(posedge clk) begin
      if (en) begin
        m2s[l][0]            <= m2w;
        side_sq[l][0].ax[0]  <= ax0[0];
        side_sq[l][0].ax[1]  <= ax0[1];
        side_sq[l][0].neg[0] <= !raw[l][0][RAW_W-1];
        side_sq[l][0].neg[1] <= !raw[l][1][RAW_W-1];
        side_sq[l][0].zero   <= 1'b0;
      end
    end

    // square root of m2 * 2^32, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      logic [SQ_REM_W-1:0] rin;
      logic [R_W-1:0]      oin;
      logic [1:0]          pr;
      logic [SQ_REM_W:0]   sh;
      logic [SQ_REM_W:0]   tr;
      if (k == 0) begin : g_first
        assign rin = '0;
        assign oin = '0;
      end else begin : g_next
        assign rin = sq_rem[l][k];
        assign oin = sq_root[l][k];
      end
      if (k < PAIRS) begin : g_pair
        assign pr = m2s[l][k][M2_W-1-2*k -: 2];
      end else begin : g_zpair
        assign pr = 2'b00;
      end
      assign sh = {rin[SQ_REM_W-2:0], pr};
      assign tr = {1'b0, oin, 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          m2s[l][k+1]     <= m2s[l][k];
          side_sq[l][k+1] <= side_sq[l][k];
          if (sh >= tr) begin
            sq_rem[l][k+1]  <= SQ_REM_W'(sh - tr);
            sq_root[l][k+1] <= {oin[R_W-2:0], 1'b1};
          end else begin
            sq_rem[l][k+1]  <= SQ_REM_W'(sh);
            sq_root[l][k+1] <= {oin[R_W-2:0], 1'b0};
          end
        end
      end
    end

    // deadzone compare and divider operands
    logic [R_W-1:0] rr, dq, mc;
    logic           zr;
    assign rr = sq_root[l][SQ_STEPS];
    assign dq = R_W'({dz[l], {DQ_SHIFT{1'b0}}});
    assign zr = (m2s[l][SQ_STEPS] == '0) || (rr < dq);
    assign mc = (rr > ONE_Q23) ? ONE_Q23 : rr;

    always_ff @(posedge clk) begin
      if (en) begin
        dm_rem[l][0]       <= zr ? '0 : DIV_REM_W'(mc - dq);
        dm_div[l][0]       <= ONE_Q23 - dq;
        dm_q[l][0]         <= '0;
        dv_r[l][0]         <= rr;
        side_dv[l][0].ax   <= side_sq[l][SQ_STEPS].ax;
        side_dv[l][0].neg  <= side_sq[l][SQ_STEPS].neg;
        side_dv[l][0].zero <= zr;
        for (int a = 0; a < 2; a++) begin
          du_rem[l][a][0] <= DIV_REM_W'({side_sq[l][SQ_STEPS].ax[a], 16'h0000});
          du_q[l][a][0]   <= '0;
        end
      end
    end

    // restoring dividers: scale factor and the two direction components
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dv
      logic [DIV_REM_W-1:0] msh;
      logic                 mge;
      assign msh = (s == 0) ? dm_rem[l][s] : {dm_rem[l][s][DIV_REM_W-2:0], 1'b0};
      assign mge = msh >= DIV_REM_W'(dm_div[l][s]);

      always_ff @(posedge clk) begin
        if (en) begin
          dm_div[l][s+1]  <= dm_div[l][s];
          dv_r[l][s+1]    <= dv_r[l][s];
          side_dv[l][s+1] <= side_dv[l][s];
          if (s < MULT_STEPS) begin
            dm_rem[l][s+1] <= mge ? DIV_REM_W'(msh - DIV_REM_W'(dm_div[l][s])) : msh;
            dm_q[l][s+1]   <= {dm_q[l][s][MULT_W-2:0], mge};
          end else begin
            dm_rem[l][s+1] <= dm_rem[l][s];
            dm_q[l][s+1]   <= dm_q[l][s];
          end
        end
      end

      for (genvar a = 0; a < 2; a++) begin : g_ua
        logic [DIV_REM_W-1:0] ush;
        logic                 uge;
        assign ush = (s == 0) ? du_rem[l][a][s] : {du_rem[l][a][s][DIV_REM_W-2:0], 1'b0};
        assign uge = ush >= DIV_REM_W'(dv_r[l][s]);

        always_ff @(posedge clk) begin
          if (en) begin
            if (s < UQ_W) begin
              du_rem[l][a][s+1] <= uge ? DIV_REM_W'(ush - DIV_REM_W'(dv_r[l][s])) : ush;
              du_q[l][a][s+1]   <= {du_q[l][a][s][UQ_W-2:0], uge};
            end else begin
              du_rem[l][a][s+1] <= du_rem[l][a][s];
              du_q[l][a][s+1]   <= du_q[l][a][s];
            end
          end
        end
      end
    end

    // scale each component
    always_ff @(posedge clk) begin
      if (en) begin
        side_ml[l] <= side_dv[l][DIV_STEPS];
        for (int a = 0; a < 2; a++) begin
          prod[l][a] <= PROD_W'(du_q[l][a][DIV_STEPS]) * PROD_W'(dm_q[l][DIV_STEPS]);
        end
      end
    end

    // round half up, apply sign, saturate
    for (genvar a = 0; a < 2; a++) begin : g_out
      logic [PROD_W-1:0] rs;
      logic [MX_W-1:0]   magx;
      logic [OUT_W:0]    lim;
      logic [OUT_W-1:0]  val;
      assign rs   = prod[l][a] + PROD_W'(1 << (RND_SHIFT - 1));
      assign magx = MX_W'(rs[PROD_W-1:RND_SHIFT]);

      always_comb begin
        if (side_ml[l].neg[a]) begin
          lim = (magx > MX_W'(NEG_LIMIT)) ? NEG_LIMIT : magx[OUT_W:0];
          val = OUT_W'((OUT_W+1)'(0) - lim);
        end else begin
          lim = (magx > MX_W'(POS_LIMIT)) ? POS_LIMIT : magx[OUT_W:0];
          val = lim[OUT_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ores[l][a] <= side_ml[l].zero ? '0 : val;
        end
      end
    end
  end

  assign res.valid           = vld[NST-1];
  assign res.left_horiz_out  = ores[0][0];
  assign res.left_vert_out   = ores[0][1];
  assign res.right_horiz_out = ores[1][0];
  assign res.right_vert_out  = ores[1][1];

endmodule

[sim/stick_radial_deadzone_top_test.sv]
`timescale 1ns / 100ps
// self-checking bench for stick_radial_deadzone_top: directed table, zero-deadzone rows, then random phases
// depends on srdz_pkg, srdz_samp_if.sv and stick_radial_deadzone_top.sv
module stick_radial_deadzone_top_test;
  import srdz_pkg::*;

  localparam int FRAC      = 15;
  localparam int LATENCY   = 28 + ((FRAC + 1 > 25) ? FRAC + 1 : 25);
  localparam int STALL_MAX = 4000;

  typedef struct {
    logic signed [OUT_W-1:0] lh, lv, rh, rv;
  } axes_t;

  typedef struct {
    logic [RAW_W-1:0] lh, lv, rh, rv;
    bit               typed;
    axes_t            want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LEFT_DZ;
  logic [DZ_W-1:0] cfg_data = '0;

  srdz_samp_if samp ();
  srdz_res_if  res ();

  stick_radial_deadzone_top #(.OUT_FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samp(samp), .res(res)
  );

  axes_t pending_axes[$];
  logic [DZ_W-1:0] left_dz = DZ_RESET;
  logic [DZ_W-1:0] right_dz = DZ_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    samp.valid = 0;
    samp.left_horiz_raw = 8'd128;
    samp.left_vert_raw = 8'd128;
    samp.right_horiz_raw = 8'd128;
    samp.right_vert_raw = 8'd128;
    res.ready = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] scale_axis(longint unsigned a, bit neg,
                                                  longint unsigned r, longint unsigned mult);
    longint unsigned u, mag;
    u = (a << (16 + FRAC)) / r;
    mag = (u * mult + (64'd1 << 23)) >> 24;
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return OUT_W'(64'h10000 - mag);
    end
    if (mag > 32767) mag = 32767;
    return OUT_W'(mag);
  endfunction

  function automatic void shape_stick(input logic [RAW_W-1:0] h, input logic [RAW_W-1:0] v,
                                      input logic [DZ_W-1:0] dz,
                                      output logic [OUT_W-1:0] oh,
                                      output logic [OUT_W-1:0] ov);
    int cx, cy;
    longint unsigned ax, ay, m2, dq, r, mc, mult;
    cx = int'(h) - 128;
    cy = int'(v) - 128;
    ax = longint'((cx < 0) ? -cx : cx);
    ay = longint'((cy < 0) ? -cy : cy);
    m2 = ax * ax + ay * ay;
    dq = longint'(dz) << 7;
    oh = '0;
    ov = '0;
    if (m2 == 0) return;
    r = int_sqrt(m2 << 32);
    if (r < dq) return;
    mc = (r > (64'd1 << 23)) ? (64'd1 << 23) : r;
    mult = ((mc - dq) << 24) / ((64'd1 << 23) - dq);
    oh = scale_axis(ax, cx < 0, r, mult);
    ov = scale_axis(ay, cy < 0, r, mult);
  endfunction

  function automatic axes_t predict_axes(row_t s);
    axes_t e;
    logic [OUT_W-1:0] a, b;
    shape_stick(s.lh, s.lv, left_dz, a, b);
    e.lh = a;
    e.lv = b;
    shape_stick(s.rh, s.rv, right_dz, a, b);
    e.rh = a;
    e.rv = b;
    return e;
  endfunction

  task automatic send_sample(row_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      samp.valid <= 0;
      @(posedge clk);
    end
    samp.valid <= 1;
    samp.left_horiz_raw <= s.lh;
    samp.left_vert_raw <= s.lv;
    samp.right_horiz_raw <= s.rh;
    samp.right_vert_raw <= s.rv;
    do @(posedge clk); while (!samp.ready);
    pending_axes.push_back(s.typed ? s.want : predict_axes(s));
  endtask

  task automatic drain_pipe();
    samp.valid <= 0;
    while (pending_axes.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_deadzone(logic [CFG_IDX_W-1:0] idx, logic [DZ_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_LEFT_DZ) left_dz = val;
    else right_dz = val;
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3, 4: return RAW_W'(128 + $urandom_range(40) - 20);
      default: return RAW_W'($urandom_range(255));
    endcase
  endfunction

  function automatic row_t plain(int a, int b, int c, int d);
    row_t s;
    s.lh = RAW_W'(a);
    s.lv = RAW_W'(b);
    s.rh = RAW_W'(c);
    s.rv = RAW_W'(d);
    s.typed = 0;
    return s;
  endfunction

  function automatic row_t typed(int a, int b, int c, int d, int e0, int e1, int e2, int e3);
    row_t s;
    s = plain(a, b, c, d);
    s.typed = 1;
    s.want.lh = OUT_W'(e0);
    s.want.lv = OUT_W'(e1);
    s.want.rh = OUT_W'(e2);
    s.want.rv = OUT_W'(e3);
    return s;
  endfunction

  // receiver: check each item, then pick next ready
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (pending_axes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %0d %0d %0d %0d",
            res.left_horiz_out, res.left_vert_out, res.right_horiz_out, res.right_vert_out);
        end else begin
          axes_t e;
          e = pending_axes.pop_front();
          if (e.lh !== res.left_horiz_out || e.lv !== res.left_vert_out ||
              e.rh !== res.right_horiz_out || e.rv !== res.right_vert_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                e.lh, e.lv, e.rh, e.rv, res.left_horiz_out, res.left_vert_out,
                res.right_horiz_out, res.right_vert_out);
          end
        end
      end
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((samp.valid && samp.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    row_t dir_rows[$];
    row_t s;
    int idle_modes[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{20, 20}};
    logic [DZ_W-1:0] dz_sets[6][2] = '{'{16'd0, 16'd0}, '{16'hFFFF, 16'd0},
      '{16'd0, 16'hFFFF}, '{16'hFFFF, 16'hFFFF}, '{DZ_RESET, DZ_RESET}, '{16'h8000, 16'h2AAA}};

    repeat (7) @(posedge clk);
    rst <= 0;

    // centre, full deflection and inside-deadzone rows read straight off the math
    dir_rows.push_back(typed(128, 128, 128, 128, 0, 0, 0, 0));
    dir_rows.push_back(typed(0, 128, 128, 0, -32768, 0, 0, -32768));
    dir_rows.push_back(typed(128, 0, 0, 128, 0, -32768, -32768, 0));
    dir_rows.push_back(typed(129, 128, 127, 128, 0, 0, 0, 0));
    dir_rows.push_back(typed(138, 138, 118, 118, 0, 0, 0, 0));
    dir_rows.push_back(plain(255, 255, 0, 0));
    dir_rows.push_back(plain(0, 255, 255, 0));
    dir_rows.push_back(plain(255, 128, 128, 255));
    dir_rows.push_back(plain(149, 128, 128, 107));
    dir_rows.push_back(plain(148, 128, 108, 128));
    dir_rows.push_back(plain(143, 143, 113, 113));
    dir_rows.push_back(plain(170, 85, 1, 254));
    dir_rows.push_back(plain(200, 60, 90, 220));
    foreach (dir_rows[i]) send_sample(dir_rows[i]);
    drain_pipe();

    // zero deadzone: smallest deflection reaches the output
    write_deadzone(REG_LEFT_DZ, 16'd0);
    write_deadzone(REG_RIGHT_DZ, 16'd0);
    send_sample(typed(128, 128, 128, 128, 0, 0, 0, 0));
    send_sample(plain(129, 128, 128, 127));
    send_sample(plain(0, 0, 255, 255));
    drain_pipe();

    for (int ph = 0; ph < 6; ph++) begin
      write_deadzone(REG_LEFT_DZ, ph == 5 ? DZ_W'($urandom_range(16'hFFFF)) : dz_sets[ph][0]);
      write_deadzone(REG_RIGHT_DZ, ph == 5 ? DZ_W'($urandom_range(16'hFFFF)) : dz_sets[ph][1]);
      for (int n = 0; n < 276; n++) begin
        int m;
        m = (n / 40) % 5;
        send_idle_pct = (m == 4) ? 0 : idle_modes[m][0];
        recv_stall_pct = (m == 4) ? 0 : idle_modes[m][1];
        s = plain(pick_raw(), pick_raw(), pick_raw(), pick_raw());
        send_sample(s);
      end
      send_idle_pct = 0;
      drain_pipe();
    end

    recv_stall_pct = 0;
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
